// ----- src/selb_pkg.sv -----
// ----------------------------------------------------------------------------
// selb_pkg
// Types, codes and sizes shared by the service endpoint load balancer.
// ----------------------------------------------------------------------------
package selb_pkg;

	localparam int SERVICE_SLOTS_DEF  = 16;
	localparam int ENDPOINT_SLOTS_DEF = 32;
	localparam int SID_LIMIT          = 16;
	localparam int CMD_DEPTH          = 4;
	localparam int RES_DEPTH          = 2;

	localparam logic [1:0] OP_REGISTER = 2'd0;
	localparam logic [1:0] OP_ADD      = 2'd1;
	localparam logic [1:0] OP_REQUEST  = 2'd2;
	localparam logic [1:0] OP_IGNORE   = 2'd3;

	localparam logic [2:0] MODE_ROUND_ROBIN = 3'd1;
	localparam logic [2:0] MODE_LEAST_CONN  = 3'd2;
	localparam logic [2:0] MODE_FIRST_OK    = 3'd3;
	localparam logic [2:0] MODE_RANDOM      = 3'd4;

	localparam logic [1:0] ST_OK     = 2'd0;
	localparam logic [1:0] ST_FULL   = 2'd1;
	localparam logic [1:0] ST_BAD_ID = 2'd2;
	localparam logic [1:0] ST_NONE   = 2'd3;

	typedef struct packed {
		logic [1:0]  opcode;
		logic [3:0]  svc_num;
		logic [2:0]  algorithm;
		logic [31:0] current_time;
	} req_t;

	typedef struct packed {
		logic [1:0] status;
		logic [4:0] index;
	} rsp_t;

	typedef enum logic [2:0] {
		K_RESULT,
		K_CLEAR,
		K_INC,
		K_LEAST,
		K_MOD
	} kind_t;

	typedef struct packed {
		kind_t       kind;
		logic [3:0]  sid;
		logic [4:0]  idx;
		logic [5:0]  n;
		logic [31:0] value;
		logic [1:0]  status;
	} cmd_t;

endpackage

// ----- src/selb_fifo.sv -----
// ----------------------------------------------------------------------------
// selb_fifo
// Small synchronous queue with push/full and pop/empty sides.
// ----------------------------------------------------------------------------
module selb_fifo #(
	parameter int W     = 8,
	parameter int DEPTH = 4
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         push,
	output logic         full,
	input  logic [W-1:0] wdata,
	input  logic         pop,
	output logic         empty,
	output logic [W-1:0] rdata
);
	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

	logic [W-1:0] mem_q [DEPTH];
	logic [PW-1:0] wp_q, rp_q;
	logic [PW:0]   cnt_q;
	logic          do_push, do_pop;

	assign full    = (cnt_q == (PW+1)'(DEPTH));
	assign empty   = (cnt_q == '0);
	assign do_push = push && !full;
	assign do_pop  = pop && !empty;
	assign rdata   = mem_q[rp_q];

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wp_q] <= wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= '0;
			rp_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (do_push) begin
				wp_q <= (wp_q == PW'(DEPTH - 1)) ? '0 : wp_q + 1'b1;
			end
			if (do_pop) begin
				rp_q <= (rp_q == PW'(DEPTH - 1)) ? '0 : rp_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (do_pop && !do_push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end
endmodule

// ----- src/selb_front.sv -----
// ----------------------------------------------------------------------------
// selb_front
// Accepts items, keeps the service table and turns each item other than an ignore into a command.
// ----------------------------------------------------------------------------
module selb_front import selb_pkg::*; #(
	parameter int SERVICE_SLOTS  = SERVICE_SLOTS_DEF,
	parameter int ENDPOINT_SLOTS = ENDPOINT_SLOTS_DEF
) (
	input  logic clk,
	input  logic arst_n,
	input  logic accept,
	input  req_t req,
	output logic cmd_push,
	output cmd_t cmd
);
	localparam int NSVC  = (SERVICE_SLOTS < SID_LIMIT) ? SERVICE_SLOTS : SID_LIMIT;
	localparam int SVI_W = (NSVC > 1) ? $clog2(NSVC) : 1;
	localparam int SCW   = $clog2(SERVICE_SLOTS + 1);

	logic [SCW-1:0] su_q;
	logic [5:0]     eu_q   [NSVC];
	logic [2:0]     mode_q [NSVC];
	logic [4:0]     rp_q   [NSVC];

	logic [SVI_W-1:0] sidx, widx;
	logic [5:0]       n;
	logic [4:0]       rp, rp_nxt;
	logic             sid_ok, svc_full, ep_full;

	assign sidx     = req.svc_num[SVI_W-1:0];
	assign widx     = su_q[SVI_W-1:0];
	assign sid_ok   = 32'(req.svc_num) < 32'(su_q);
	assign svc_full = 32'(su_q) >= SERVICE_SLOTS;
	assign n        = eu_q[sidx];
	assign rp       = rp_q[sidx];
	assign ep_full  = 32'(n) >= ENDPOINT_SLOTS;
	assign rp_nxt   = (6'(rp) + 6'd1 == n) ? 5'd0 : rp + 5'd1;
	assign cmd_push = accept && (req.opcode != OP_IGNORE);

	always_comb begin
		cmd        = '0;
		cmd.kind   = K_RESULT;
		cmd.sid    = req.svc_num;
		cmd.n      = n;
		cmd.status = ST_OK;
		case (req.opcode)
			OP_REGISTER: begin
				if (svc_full) begin
					cmd.status = ST_FULL;
				end else begin
					cmd.idx = 5'(su_q);
				end
			end
			OP_ADD: begin
				if (!sid_ok) begin
					cmd.status = ST_BAD_ID;
				end else if (ep_full) begin
					cmd.status = ST_FULL;
				end else begin
					cmd.kind = K_CLEAR;
					cmd.idx  = n[4:0];
				end
			end
			OP_REQUEST: begin
				if (!sid_ok) begin
					cmd.status = ST_BAD_ID;
				end else if (n == '0) begin
					cmd.status = ST_NONE;
				end else begin
					case (mode_q[sidx])
						MODE_ROUND_ROBIN: begin
							cmd.kind = K_INC;
							cmd.idx  = rp;
						end
						MODE_LEAST_CONN: cmd.kind = K_LEAST;
						MODE_FIRST_OK:   cmd.kind = K_INC;
						MODE_RANDOM: begin
							cmd.kind  = K_MOD;
							cmd.value = (req.current_time << 3) - req.current_time
								+ 32'(req.svc_num);
						end
						default: cmd.status = ST_NONE;
					endcase
				end
			end
			default: cmd.status = ST_OK;
		endcase
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			if (req.opcode == OP_REGISTER && !svc_full && 32'(su_q) < NSVC) begin
				eu_q[widx]   <= '0;
				mode_q[widx] <= req.algorithm;
				rp_q[widx]   <= '0;
			end
			if (req.opcode == OP_ADD && sid_ok && !ep_full) begin
				eu_q[sidx] <= n + 6'd1;
			end
			if (req.opcode == OP_REQUEST && sid_ok && n != '0
					&& mode_q[sidx] == MODE_ROUND_ROBIN) begin
				rp_q[sidx] <= rp_nxt;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			su_q <= '0;
		end else if (accept && req.opcode == OP_REGISTER && !svc_full) begin
			su_q <= su_q + 1'b1;
		end
	end
endmodule

// ----- src/selb_back.sv -----
// ----------------------------------------------------------------------------
// selb_back
// Carries out commands on the connection counters and produces results.
// ----------------------------------------------------------------------------
module selb_back import selb_pkg::*; #(
	parameter int SERVICE_SLOTS  = SERVICE_SLOTS_DEF,
	parameter int ENDPOINT_SLOTS = ENDPOINT_SLOTS_DEF
) (
	input  logic clk,
	input  logic arst_n,
	input  logic cmd_empty,
	output logic cmd_pop,
	input  cmd_t cmd,
	input  logic res_full,
	output logic res_push,
	output rsp_t res
);
	localparam int NSVC  = (SERVICE_SLOTS < SID_LIMIT) ? SERVICE_SLOTS : SID_LIMIT;
	localparam int MEM_D = NSVC * ENDPOINT_SLOTS;
	localparam int AW    = (MEM_D > 1) ? $clog2(MEM_D) : 1;

	typedef enum logic [2:0] {
		S_IDLE, S_CLR, S_SCAN, S_DIV, S_RD, S_WAIT, S_WR
	} state_t;

	state_t      state_q;
	logic [31:0] mem [MEM_D];
	logic [31:0] rdata_q, best_q, sat, wdata;
	logic [3:0]  sid_q;
	logic [4:0]  idx_q, bi_q, dj_q, dc_q;
	logic [5:0]  n_q, ic_q, r_q, r_nxt;
	logic [6:0]  rn;
	logic [31:0] dq_q;
	logic        dv_q, take, we, res_push_q;
	logic [AW-1:0] raddr, waddr;
	rsp_t        res_q;

	function automatic logic [AW-1:0] addr(input logic [3:0] s, input logic [4:0] e);
		addr = AW'(32'(s) * ENDPOINT_SLOTS + 32'(e));
	endfunction

	assign cmd_pop  = (state_q == S_IDLE) && !cmd_empty && !res_full && !res_push_q;
	assign res_push = res_push_q;
	assign res      = res_q;
	assign take     = (dj_q == '0) || (rdata_q < best_q);
	assign sat      = (best_q == 32'hFFFF_FFFF) ? best_q : best_q + 32'd1;
	assign rn       = {r_q, dq_q[31]};
	assign r_nxt    = (rn >= {1'b0, n_q}) ? 6'(rn - {1'b0, n_q}) : rn[5:0];
	assign raddr    = (state_q == S_SCAN) ? addr(sid_q, ic_q[4:0]) : addr(sid_q, idx_q);
	assign we       = (state_q == S_CLR) || (state_q == S_WR);
	assign waddr    = (state_q == S_WR) ? addr(sid_q, bi_q) : addr(sid_q, idx_q);
	assign wdata    = (state_q == S_WR) ? sat : 32'd0;

	always_ff @(posedge clk) begin
		rdata_q <= mem[raddr];
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_IDLE;
			res_push_q <= 1'b0;
			dv_q       <= 1'b0;
		end else begin
			res_push_q <= 1'b0;
			case (state_q)
				S_IDLE: begin
					if (cmd_pop) begin
						sid_q <= cmd.sid;
						idx_q <= cmd.idx;
						n_q   <= cmd.n;
						ic_q  <= '0;
						dv_q  <= 1'b0;
						dq_q  <= cmd.value;
						r_q   <= '0;
						dc_q  <= '0;
						case (cmd.kind)
							K_CLEAR: state_q <= S_CLR;
							K_INC:   state_q <= S_RD;
							K_LEAST: state_q <= S_SCAN;
							K_MOD:   state_q <= S_DIV;
							default: begin
								res_q      <= '{status: cmd.status, index: cmd.idx};
								res_push_q <= 1'b1;
							end
						endcase
					end
				end
				S_CLR: begin
					res_q      <= '{status: ST_OK, index: idx_q};
					res_push_q <= 1'b1;
					state_q    <= S_IDLE;
				end
				S_SCAN: begin
					if (ic_q != n_q) begin
						ic_q <= ic_q + 6'd1;
						dv_q <= 1'b1;
						dj_q <= ic_q[4:0];
					end else begin
						dv_q <= 1'b0;
					end
					if (dv_q && take) begin
						best_q <= rdata_q;
						bi_q   <= dj_q;
					end
					if (dv_q && ic_q == n_q) begin
						state_q <= S_WR;
					end
				end
				S_DIV: begin
					r_q  <= r_nxt;
					dq_q <= dq_q << 1;
					dc_q <= dc_q + 5'd1;
					if (dc_q == 5'd31) begin
						idx_q   <= r_nxt[4:0];
						state_q <= S_RD;
					end
				end
				S_RD: state_q <= S_WAIT;
				S_WAIT: begin
					best_q  <= rdata_q;
					bi_q    <= idx_q;
					state_q <= S_WR;
				end
				S_WR: begin
					res_q      <= '{status: ST_OK, index: bi_q};
					res_push_q <= 1'b1;
					state_q    <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end
endmodule

// ----- src/service_endpoint_load_balancer.sv -----
// Throughput: the front takes one item per cycle into a 4-entry queue while it is
// not full; the back runs one command at a time, set by the counter scan and the
// 32-step remainder unit.
// Reset clears the service count and the queues; the tables need no clearing pass.
// ----------------------------------------------------------------------------
// service_endpoint_load_balancer
// Service table with per-service endpoint selection and connection counting.
// ----------------------------------------------------------------------------
module service_endpoint_load_balancer import selb_pkg::*; #(
	parameter int SERVICE_SLOTS  = SERVICE_SLOTS_DEF,
	parameter int ENDPOINT_SLOTS = ENDPOINT_SLOTS_DEF
) (
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	output logic full,
	input  req_t req,
	output logic empty,
	input  logic pop,
	output rsp_t rsp
);
	logic cmd_push, cmd_full, cmd_pop, cmd_empty, res_push, res_full;
	cmd_t cmd_w, cmd_r;
	rsp_t res_w;

	assign full = cmd_full;

	selb_front #(.SERVICE_SLOTS(SERVICE_SLOTS), .ENDPOINT_SLOTS(ENDPOINT_SLOTS)) u_front (
		.clk(clk), .arst_n(arst_n), .accept(push && !full), .req(req),
		.cmd_push(cmd_push), .cmd(cmd_w)
	);

	selb_fifo #(.W($bits(cmd_t)), .DEPTH(CMD_DEPTH)) u_cmdq (
		.clk(clk), .arst_n(arst_n), .push(cmd_push), .full(cmd_full), .wdata(cmd_w),
		.pop(cmd_pop), .empty(cmd_empty), .rdata(cmd_r)
	);

	selb_back #(.SERVICE_SLOTS(SERVICE_SLOTS), .ENDPOINT_SLOTS(ENDPOINT_SLOTS)) u_back (
		.clk(clk), .arst_n(arst_n), .cmd_empty(cmd_empty), .cmd_pop(cmd_pop), .cmd(cmd_r),
		.res_full(res_full), .res_push(res_push), .res(res_w)
	);

	selb_fifo #(.W($bits(rsp_t)), .DEPTH(RES_DEPTH)) u_resq (
		.clk(clk), .arst_n(arst_n), .push(res_push), .full(res_full), .wdata(res_w),
		.pop(pop), .empty(empty), .rdata(rsp)
	);

	a_res_room: assert property (@(posedge clk) disable iff (!arst_n)
		res_push |-> !res_full) else $error("result written into a full queue");
	a_cmd_avail: assert property (@(posedge clk) disable iff (!arst_n)
		cmd_pop |-> !cmd_empty) else $error("command taken from an empty queue");
	a_cmd_lands: assert property (@(posedge clk) disable iff (!arst_n)
		cmd_push && !cmd_full |=> !cmd_empty) else $error("queued command was lost");
endmodule
